// File: rtl/lbps_pkg.sv
// Package with the shared types and codes of the LED blink pattern sequencer.
package lbps_pkg;

	localparam int unsigned TICK_W = 16;
	localparam int unsigned LOOP_W = 16;
	localparam int unsigned SECT_W = 2;
	localparam int unsigned SCNT_W = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IN_DATA_W = 8;
	localparam int unsigned IN_USER_W = 2;
	localparam int unsigned OUT_DATA_W = 8;

	// Request kinds carried on the input tuser.
	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_STOP = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTION_TICKS_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTION_TICKS_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTION_TICKS_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTION_TICKS_3 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_TOTAL = 3'd5;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;
	localparam logic [LOOP_W-1:0] LOOP_FOREVER = '1;

	typedef struct packed {
		logic [SCNT_W-1:0] section_count;
		logic [3:0][TICK_W-1:0] section_ticks;
		logic [LOOP_W-1:0] loop_total;
	} lbps_cfg_t;

	typedef struct packed {
		logic status;
		logic running;
		logic level_driven;
		logic led_level;
	} lbps_result_t;

endpackage

// File: rtl/lbps_seq.sv
// Run state of the blink pattern and the per-request update logic.
module lbps_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [1:0]           req_type,
	input  logic                 start_level,
	input  lbps_pkg::lbps_cfg_t  cfg,
	output lbps_pkg::lbps_result_t result
);
	import lbps_pkg::*;

	logic              active_q;
	logic [TICK_W-1:0] tick_count_q;
	logic [SECT_W-1:0] section_index_q;
	logic [LOOP_W-1:0] loop_count_q;
	logic              level_q;
	logic              initial_level_q;

	logic              active_d;
	logic [TICK_W-1:0] tick_count_d;
	logic [SECT_W-1:0] section_index_d;
	logic [LOOP_W-1:0] loop_count_d;
	logic              level_d;
	logic              initial_level_d;
	logic              driven;
	logic              status;

	logic [SCNT_W-1:0] used_sections;
	logic [SCNT_W-1:0] next_section;
	logic [LOOP_W-1:0] loop_inc;
	logic              elapsed;
	logic              wrap;
	logic              last_loop;
	logic [TICK_W-1:0] tick_mid;
	logic [SECT_W-1:0] section_mid;

	always_comb begin
		// Out-of-range section counts clamp to the 1..4 range.
		if (cfg.section_count == '0) begin
			used_sections = SCNT_W'(1);
		end else if (cfg.section_count > SCNT_W'(4)) begin
			used_sections = SCNT_W'(4);
		end else begin
			used_sections = cfg.section_count;
		end
		elapsed = tick_count_q >= cfg.section_ticks[section_index_q];
		next_section = SCNT_W'(section_index_q) + SCNT_W'(1);
		wrap = next_section >= used_sections;
		loop_inc = loop_count_q + LOOP_W'(1);
		last_loop = (loop_inc >= cfg.loop_total) && (cfg.loop_total != LOOP_FOREVER);
		tick_mid = elapsed ? '0 : tick_count_q;
		section_mid = section_index_q;
		if (elapsed) begin
			section_mid = wrap ? '0 : next_section[SECT_W-1:0];
		end
	end

	always_comb begin
		active_d = active_q;
		tick_count_d = tick_count_q;
		section_index_d = section_index_q;
		loop_count_d = loop_count_q;
		level_d = level_q;
		initial_level_d = initial_level_q;
		driven = 1'b0;
		status = 1'b0;
		case (req_type)
			REQ_TICK: begin
				if (active_q) begin
					if (elapsed && wrap) begin
						if (last_loop) begin
							active_d = 1'b0;
							loop_count_d = '0;
						end else begin
							loop_count_d = loop_inc;
						end
					end
					section_index_d = section_mid;
					if (tick_mid == '0) begin
						level_d = (section_mid == '0) ? initial_level_q : ~level_q;
						driven = 1'b1;
					end
					tick_count_d = (tick_mid != TICK_MAX) ? tick_mid + TICK_W'(1) : tick_mid;
				end
			end
			REQ_START: begin
				initial_level_d = start_level;
				if (active_q) begin
					status = 1'b1;
				end else begin
					tick_count_d = '0;
					loop_count_d = '0;
					section_index_d = '0;
					level_d = start_level;
					active_d = 1'b1;
				end
			end
			REQ_STOP: begin
				active_d = 1'b0;
			end
			default: begin
			end
		endcase
		result.led_level = level_d;
		result.level_driven = driven;
		result.running = active_d;
		result.status = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			tick_count_q <= '0;
			section_index_q <= '0;
			loop_count_q <= '0;
			level_q <= 1'b0;
			initial_level_q <= 1'b0;
		end else if (fire) begin
			active_q <= active_d;
			tick_count_q <= tick_count_d;
			section_index_q <= section_index_d;
			loop_count_q <= loop_count_d;
			level_q <= level_d;
			initial_level_q <= initial_level_d;
		end
	end

	// A start always leaves the pattern running.
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req_type == REQ_START |=> active_q)
		else $error("start did not leave the pattern running");

	// A stop always halts the pattern.
	a_stop_halts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req_type == REQ_STOP |=> !active_q)
		else $error("stop did not halt the pattern");

	// A tick while idle leaves the counters and the level alone.
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req_type == REQ_TICK && !active_q
		|=> $stable(tick_count_q) && $stable(level_q) && $stable(section_index_q))
		else $error("idle tick changed the run state");

	// The LED is only driven by a tick of a running pattern.
	a_drive_active: assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.level_driven |-> active_q && req_type == REQ_TICK)
		else $error("LED driven outside a running tick");

endmodule

// File: rtl/led_blink_pattern_sequencer_unit.sv
// Top level of the LED blink pattern sequencer: handshakes, configuration and result register.
//
//  Channel   Direction  Signals                         Payload
//  s_*       in         s_tvalid s_tready s_tdata s_tuser   tuser: req_type; tdata: start_level
//  m_*       out        m_tvalid m_tready m_tdata           led_level, level_driven, running, status
//  cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data  register index and value
//
// Each request is captured in an input stage, processed by the combinational
// sequencer logic and lands in the result register, so the unit sustains one
// request per clock while results are taken. The input stage and the result
// register each hold one request; the input stage hands its request on
// whenever the result register is empty or being drained. When a result waits
// and the input stage is full, s_tready drops until the result is taken. A
// result becomes valid when its request moves from the input stage into the result register.
// Reset clears the run state and loads the configuration defaults (one
// section, zero durations, zero loops). Configuration writes are always
// accepted and take effect at once.
module led_blink_pattern_sequencer_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// start_level in bit 0, remaining bits zero
	input  logic [lbps_pkg::IN_DATA_W-1:0]       s_tdata,
	// req_type in bits 1:0
	input  logic [lbps_pkg::IN_USER_W-1:0]       s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// led_level bit 0, level_driven bit 1, running bit 2, status bit 3, rest zero
	output logic [lbps_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lbps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lbps_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import lbps_pkg::*;

	lbps_cfg_t    cfg_q;
	logic         in_valid_s1;
	logic [1:0]   req_type_s1;
	logic         start_level_s1;
	logic         out_valid_q;
	lbps_result_t out_q;
	lbps_result_t result;
	logic         advance;
	logic         in_fire;

	// The input stage hands its request on when the result register can take it.
	assign advance = in_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || advance;
	assign in_fire = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.section_count <= SCNT_W'(1);
			cfg_q.section_ticks <= '0;
			cfg_q.loop_total <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SECTION_COUNT: cfg_q.section_count <= cfg_data[SCNT_W-1:0];
				CFG_SECTION_TICKS_0: cfg_q.section_ticks[0] <= cfg_data;
				CFG_SECTION_TICKS_1: cfg_q.section_ticks[1] <= cfg_data;
				CFG_SECTION_TICKS_2: cfg_q.section_ticks[2] <= cfg_data;
				CFG_SECTION_TICKS_3: cfg_q.section_ticks[3] <= cfg_data;
				CFG_LOOP_TOTAL: cfg_q.loop_total <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Control bits of the two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				in_valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_type_s1 <= s_tuser;
			start_level_s1 <= s_tdata[0];
		end
		if (advance) begin
			out_q <= result;
		end
	end

	lbps_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.req_type    (req_type_s1),
		.start_level (start_level_s1),
		.cfg         (cfg_q),
		.result      (result)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata = {(OUT_DATA_W - 4)'(0), out_q.status, out_q.running,
		out_q.level_driven, out_q.led_level};

endmodule
